>>> design/pbu_pkg.sv
// Package for the belief update block: sizes, widths, function codes, register
// addresses and the memory request and response structs. No dependencies.
`default_nettype none
package pbu_pkg;
  localparam int STATES       = 16;
  localparam int ACTIONS      = 4;
  localparam int OBSERVATIONS = 4;

  localparam int ST_W   = $clog2(STATES);
  localparam int ACT_W  = $clog2(ACTIONS);
  localparam int OBS_W  = $clog2(OBSERVATIONS);
  localparam int CNT_W  = 5;
  localparam int PROB_W = 17;
  localparam int T_AW   = 2 * ST_W + ACT_W;
  localparam int O_AW   = T_AW + OBS_W;
  localparam int U_W    = 57;
  localparam int MA_W   = 37;
  localparam int MP_W   = MA_W + PROB_W;

  localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [2:0] FUNC_LOAD_T  = 3'd0;
  localparam logic [2:0] FUNC_LOAD_O  = 3'd1;
  localparam logic [2:0] FUNC_LOAD_B  = 3'd2;
  localparam logic [2:0] FUNC_UPDATE  = 3'd3;
  localparam logic [2:0] FUNC_READ_B  = 3'd4;

  localparam logic [2:0] REG_EVENT  = 3'h0;
  localparam logic [2:0] REG_NSTATE = 3'h4;

  typedef struct packed {
    logic              t_we;
    logic              o_we;
    logic              b_we;
    logic              u_we;
    logic [T_AW-1:0]   t_addr;
    logic [O_AW-1:0]   o_addr;
    logic [ST_W-1:0]   b_waddr;
    logic [ST_W-1:0]   b_raddr;
    logic [ST_W-1:0]   u_addr;
    logic [PROB_W-1:0] wdata;
    logic [U_W-1:0]    u_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [PROB_W-1:0] t_rd;
    logic [PROB_W-1:0] o_rd;
    logic [PROB_W-1:0] b_rd;
    logic [U_W-1:0]    u_rd;
  } mem_rsp_t;
endpackage
`default_nettype wire

>>> design/pbu_mem.sv
// Storage of the belief update block: transition, observation, belief and
// unnormalized belief memories with registered reads. Uses pbu_pkg.
`default_nettype none
module pbu_mem (
  input  wire logic              clk,
  input  wire pbu_pkg::mem_req_t req,
  output pbu_pkg::mem_rsp_t      rsp
);
  import pbu_pkg::*;

  logic [PROB_W-1:0] t_mem [2**T_AW];
  logic [PROB_W-1:0] o_mem [2**O_AW];
  logic [PROB_W-1:0] b_mem [STATES];
  logic [U_W-1:0]    u_mem [STATES];

  always_ff @(posedge clk) begin
    if (req.t_we) t_mem[req.t_addr] <= req.wdata;
    if (req.o_we) o_mem[req.o_addr] <= req.wdata;
    if (req.b_we) b_mem[req.b_waddr] <= req.wdata;
    if (req.u_we) u_mem[req.u_addr] <= req.u_wdata;
    rsp.t_rd <= t_mem[req.t_addr];
    rsp.o_rd <= o_mem[req.o_addr];
    rsp.b_rd <= b_mem[req.b_raddr];
    rsp.u_rd <= u_mem[req.u_addr];
  end
endmodule
`default_nettype wire

>>> design/pbu_core.sv
// Sequencer of the belief update block: one shared multiplier and one
// compare/subtract step for division, plus the result register. Uses pbu_pkg.
`default_nettype none
module pbu_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      event_mode,
  input  wire logic [pbu_pkg::CNT_W-1:0] num_states,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [2:0]                in_func,
  input  wire logic [pbu_pkg::ST_W-1:0]  in_prev,
  input  wire logic [pbu_pkg::ACT_W-1:0] in_action,
  input  wire logic [pbu_pkg::ST_W-1:0]  in_next,
  input  wire logic [pbu_pkg::OBS_W-1:0] in_obs,
  input  wire logic [pbu_pkg::PROB_W-1:0] in_prob,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [pbu_pkg::PROB_W-1:0]     out_value,
  output logic                           out_zero,
  output pbu_pkg::mem_req_t              req,
  input  wire pbu_pkg::mem_rsp_t         rsp
);
  import pbu_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_RDW   = 13'h0002,
    S_RESP  = 13'h0004,
    S_RD    = 13'h0008,
    S_MT    = 13'h0010,
    S_MO    = 13'h0020,
    S_ACC   = 13'h0040,
    S_FINM  = 13'h0080,
    S_FINW  = 13'h0100,
    S_DRD   = 13'h0200,
    S_DLD   = 13'h0400,
    S_DSTEP = 13'h0800,
    S_DWR   = 13'h1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ST_W-1:0]   s_r, s_nxt, n_r, n_nxt;
  logic [ACT_W-1:0]  a_r, a_nxt;
  logic [OBS_W-1:0]  o_r, o_nxt;
  logic [PROB_W-1:0] ow_r, ow_nxt;
  logic [MP_W-1:0]   mul_r, mul_nxt;
  logic [U_W-1:0]    acc_r, acc_nxt, tot_r, tot_nxt, u_sel;
  logic [U_W:0]      rem_r, rem_nxt, rem_sub;
  logic [PROB_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROB_W-1:0] pv_r, pv_nxt;
  logic              pz_r, pz_nxt;
  logic              ov_r, ov_nxt, oz_r, oz_nxt;
  logic [PROB_W-1:0] oval_r, oval_nxt;
  logic [MA_W-1:0]   mul_a;
  logic [PROB_W-1:0] mul_b, pclamp;
  logic [ST_W-1:0]   last;
  logic              in_fire, rem_ge;
  logic [U_W-1:0]    tot_hi;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_value  = oval_r;
  assign out_zero   = oz_r;
  assign pclamp     = (in_prob > ONE_Q16) ? ONE_Q16 : in_prob;

  always_comb begin
    if (num_states == '0) last = '0;
    else if (num_states > CNT_W'(STATES)) last = ST_W'(STATES - 1);
    else last = ST_W'(num_states - 1'b1);
  end

  assign u_sel   = event_mode ? acc_r : U_W'(mul_r);
  assign rem_ge  = rem_r >= {1'b0, tot_r};
  assign rem_sub = rem_ge ? (rem_r - {1'b0, tot_r}) : rem_r;
  assign tot_hi  = tot_r >> 32;

  always_comb begin
    req.t_we    = 1'b0;
    req.o_we    = 1'b0;
    req.b_we    = 1'b0;
    req.u_we    = 1'b0;
    req.t_addr  = {s_r, a_r, n_r};
    req.o_addr  = {(event_mode ? s_r : ST_W'(0)), a_r, n_r, o_r};
    req.b_waddr = n_r;
    req.b_raddr = s_r;
    req.u_addr  = n_r;
    req.wdata   = q_r;
    req.u_wdata = u_sel;
    if (state_r == S_IDLE) begin
      req.t_addr  = {in_prev, in_action, in_next};
      req.o_addr  = {in_prev, in_action, in_next, in_obs};
      req.b_waddr = in_next;
      req.b_raddr = in_next;
      req.wdata   = pclamp;
      req.t_we    = in_fire && (in_func == FUNC_LOAD_T);
      req.o_we    = in_fire && (in_func == FUNC_LOAD_O);
      req.b_we    = in_fire && (in_func == FUNC_LOAD_B);
    end
    req.b_we = req.b_we || (state_r == S_DWR);
    req.u_we = (state_r == S_FINW);
  end

  always_comb begin
    mul_a = MA_W'(rsp.t_rd);
    mul_b = rsp.b_rd;
    if (state_r == S_MO) begin
      mul_a = mul_r[MA_W-1:0];
      mul_b = ow_r;
    end else if (state_r == S_FINM) begin
      mul_a = acc_r[MA_W-1:0];
      mul_b = ow_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    s_nxt = s_r; n_nxt = n_r; a_nxt = a_r; o_nxt = o_r; ow_nxt = ow_r;
    mul_nxt = mul_r; acc_nxt = acc_r; tot_nxt = tot_r;
    rem_nxt = rem_r; q_nxt = q_r; cnt_nxt = cnt_r;
    pv_nxt = pv_r; pz_nxt = pz_r;
    ov_nxt = ov_r && !out_tready; oz_nxt = oz_r; oval_nxt = oval_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pv_nxt = '0;
          pz_nxt = 1'b0;
          a_nxt = in_action;
          o_nxt = in_obs;
          s_nxt = '0;
          n_nxt = '0;
          acc_nxt = '0;
          tot_nxt = '0;
          if (in_func == FUNC_UPDATE) state_nxt = S_RD;
          else if (in_func == FUNC_READ_B) state_nxt = S_RDW;
          else state_nxt = S_RESP;
        end
      end
      S_RDW: begin
        pv_nxt = rsp.b_rd;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          oval_nxt = pv_r;
          oz_nxt = pz_r;
          state_nxt = S_IDLE;
        end
      end
      S_RD: state_nxt = S_MT;
      S_MT: begin
        mul_nxt = mul_a * mul_b;
        ow_nxt = rsp.o_rd;
        state_nxt = event_mode ? S_MO : S_ACC;
      end
      S_MO: begin
        mul_nxt = mul_a * mul_b;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = acc_r + U_W'(mul_r);
        if (s_r == last) state_nxt = event_mode ? S_FINW : S_FINM;
        else begin
          s_nxt = s_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_FINM: begin
        mul_nxt = mul_a * mul_b;
        state_nxt = S_FINW;
      end
      S_FINW: begin
        tot_nxt = tot_r + u_sel;
        acc_nxt = '0;
        s_nxt = '0;
        if (n_r == last) begin
          n_nxt = '0;
          if (tot_nxt == '0) begin
            pz_nxt = 1'b1;
            state_nxt = S_RESP;
          end else state_nxt = S_DRD;
        end else begin
          n_nxt = n_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DRD: state_nxt = S_DLD;
      S_DLD: begin
        rem_nxt = {1'b0, rsp.u_rd};
        q_nxt = '0;
        cnt_nxt = '0;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        q_nxt = {q_r[PROB_W-2:0], rem_ge};
        rem_nxt = {rem_sub[U_W-1:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PROB_W - 1)) state_nxt = S_DWR;
      end
      S_DWR: begin
        if (n_r == last) begin
          pv_nxt = (tot_hi > U_W'(ONE_Q16)) ? ONE_Q16 : tot_hi[PROB_W-1:0];
          state_nxt = S_RESP;
        end else begin
          n_nxt = n_r + 1'b1;
          state_nxt = S_DRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt; n_r <= n_nxt; a_r <= a_nxt; o_r <= o_nxt; ow_r <= ow_nxt;
    mul_r <= mul_nxt; acc_r <= acc_nxt; tot_r <= tot_nxt;
    rem_r <= rem_nxt; q_r <= q_nxt; cnt_r <= cnt_nxt;
    pv_r <= pv_nxt; pz_r <= pz_nxt; oz_r <= oz_nxt; oval_r <= oval_nxt;
  end

`ifndef SYNTHESIS
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oz_r) |-> (oval_r == '0)) else $error("zero evidence with value");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DSTEP) |-> (rem_r < {tot_r, 1'b0})) else $error("remainder bound");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DWR) |-> (tot_r != '0)) else $error("divide by zero");
  a_resp_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && state_nxt == S_IDLE) |=> ov_r) else $error("result lost");
`endif
endmodule
`default_nettype wire

>>> design/pomdp_belief_update_top.sv
// Top level of the belief update block: stream ports, register port and
// the core and memory instances. Uses pbu_pkg, pbu_core, pbu_mem.
//
// Every item gives one result. Loads and unused codes pass through a response
// state, a belief read also through a read-wait state. An update walks every
// (next state, previous state) pair through one shared multiplier: read,
// transition multiply, observation multiply in event mode only, accumulate;
// per next state an observation multiply in plain mode and a write, then a
// restoring divide per state unless the total is zero. A result waiting at
// the output holds the next item in its response state. The input is not
// ready while an item is at work. Table contents are undefined until loaded.
`default_nettype none
module pomdp_belief_update_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // prev_state[3:0], action[5:4], next_state[9:6], observation[11:10],
  // prob[28:12], zero pad
  input  wire logic [31:0] in_tdata,
  // func[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // value[16:0], zero pad
  output logic [23:0]      out_tdata,
  // zero_evidence[0]
  output logic [0:0]       out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import pbu_pkg::*;

  logic              event_r;
  logic [CNT_W-1:0]  nstates_r;
  logic              cfg_wr;
  mem_req_t          req;
  mem_rsp_t          rsp;
  logic [PROB_W-1:0] value;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      event_r   <= 1'b0;
      nstates_r <= CNT_W'(STATES);
    end else if (cfg_wr) begin
      if (cfg_paddr == REG_EVENT) event_r <= cfg_pwdata[0];
      if (cfg_paddr == REG_NSTATE) nstates_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    case (cfg_paddr)
      REG_EVENT:  cfg_prdata = {31'd0, event_r};
      REG_NSTATE: cfg_prdata = {27'd0, nstates_r};
      default:    cfg_prdata = '0;
    endcase
  end

  pbu_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .event_mode (event_r),
    .num_states (nstates_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .in_prev    (in_tdata[3:0]),
    .in_action  (in_tdata[5:4]),
    .in_next    (in_tdata[9:6]),
    .in_obs     (in_tdata[11:10]),
    .in_prob    (in_tdata[28:12]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (value),
    .out_zero   (out_tuser[0]),
    .req        (req),
    .rsp        (rsp)
  );

  pbu_mem u_mem (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  assign out_tdata = {7'd0, value};
endmodule
`default_nettype wire

>>> tb/pbu_belief_checker.sv
// Checker for the belief update block: watches the stream and register ports,
// predicts every result and compares it. Depends on pbu_pkg.
`timescale 1ns / 1ps
module pbu_belief_checker
  import pbu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic [2:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,
  input  wire logic [0:0]  out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               err_count,
  output int               pending
);
  typedef struct {
    logic [PROB_W-1:0] value;
    logic              zero_ev;
  } belief_result_t;

  localparam logic [63:0] U57_MASK = (64'd1 << U_W) - 64'd1;

  logic [PROB_W-1:0] trans_mem [1024];
  logic [PROB_W-1:0] obs_mem   [4096];
  logic [PROB_W-1:0] bel_mem   [STATES];
  logic [63:0]       unorm_mem [STATES];
  logic              event_mode;
  logic [CNT_W-1:0]  nstate_reg;
  belief_result_t    expected_q[$];

  initial begin
    err_count = 0;
    pending   = 0;
  end

  function automatic logic [PROB_W-1:0] sat_prob(logic [63:0] p);
    return (p > 64'(ONE_Q16)) ? ONE_Q16 : p[PROB_W-1:0];
  endfunction

  function automatic logic [PROB_W-1:0] q16_quotient(logic [63:0] num, logic [63:0] den);
    logic [127:0] q;
    if (num / den >= 64'd2) return ONE_Q16;
    q = ({64'd0, num} << 16) / {64'd0, den};
    return (q > 128'(ONE_Q16)) ? ONE_Q16 : q[PROB_W-1:0];
  endfunction

  function automatic belief_result_t bayes_update(logic [1:0] a, logic [1:0] o);
    belief_result_t r;
    int             cnt;
    logic [63:0]    total, u, acc;
    logic [64:0]    sum;
    cnt   = (nstate_reg == 0) ? 1 : (nstate_reg > STATES) ? STATES : int'(nstate_reg);
    total = 0;
    for (int n = 0; n < cnt; n++) begin
      u   = 0;
      acc = 0;
      for (int s = 0; s < cnt; s++) begin
        if (!event_mode) begin
          acc += 64'(trans_mem[{4'(s), a, 4'(n)}]) * 64'(bel_mem[s]);
        end else begin
          u += 64'(obs_mem[{4'(s), a, 4'(n), o}]) *
               (64'(trans_mem[{4'(s), a, 4'(n)}]) * 64'(bel_mem[s]));
        end
      end
      if (!event_mode) u = 64'(obs_mem[{4'd0, a, 4'(n), o}]) * acc;
      u            = u & U57_MASK;
      unorm_mem[n] = u;
      sum          = {1'b0, total} + {1'b0, u};
      total        = sum[64] ? '1 : sum[63:0];
    end
    if (total == 0) begin
      r.value   = '0;
      r.zero_ev = 1'b1;
      return r;
    end
    for (int n = 0; n < cnt; n++) bel_mem[n] = q16_quotient(unorm_mem[n], total);
    r.value   = sat_prob(total >> 32);
    r.zero_ev = 1'b0;
    return r;
  endfunction

  function automatic belief_result_t apply_item(logic [2:0] f, logic [31:0] d);
    belief_result_t    r;
    logic [3:0]        ps, ns;
    logic [1:0]        a, o;
    logic [PROB_W-1:0] p;
    ps        = d[3:0];
    a         = d[5:4];
    ns        = d[9:6];
    o         = d[11:10];
    p         = sat_prob(64'(d[28:12]));
    r.value   = '0;
    r.zero_ev = 1'b0;
    case (f)
      FUNC_LOAD_T: trans_mem[{ps, a, ns}]  = p;
      FUNC_LOAD_O: obs_mem[{ps, a, ns, o}] = p;
      FUNC_LOAD_B: bel_mem[ns]             = p;
      FUNC_UPDATE: r                       = bayes_update(a, o);
      FUNC_READ_B: r.value                 = bel_mem[ns];
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    belief_result_t e;
    if (!rst_n) begin
      event_mode = 1'b0;
      nstate_reg = CNT_W'(STATES);
      expected_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == REG_EVENT) event_mode = cfg_pwdata[0];
        else if (cfg_paddr == REG_NSTATE) nstate_reg = cfg_pwdata[CNT_W-1:0];
      end
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result value", 32'(out_tdata), 32'd0);
        end else begin
          e = expected_q.pop_front();
          if (out_tdata[PROB_W-1:0] !== e.value)
            report("value", 32'(out_tdata[PROB_W-1:0]), 32'(e.value));
          if (out_tuser[0] !== e.zero_ev)
            report("zero_evidence", 32'(out_tuser[0]), 32'(e.zero_ev));
        end
      end
      if (in_tvalid && in_tready) expected_q = {expected_q, apply_item(in_tuser, in_tdata)};
    end
    pending = expected_q.size();
  end
endmodule

>>> tb/tb_pomdp_belief_update_top.sv
// Testbench top for the belief update block: clock, reset, stimulus, idling
// and verdict. Depends on pbu_pkg, pomdp_belief_update_top, pbu_belief_checker.
`timescale 1ns / 1ps
module tb_pomdp_belief_update_top;
  import pbu_pkg::*;

  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam int         STALL_LIMIT   = 20000;
  localparam int         HOLD_CYCLES   = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          err_count;
  int          pending;

  int          tx_idle = 0;
  int          rx_idle = 0;
  bit          hold_req = 1'b0;
  int          hold_cnt = 0;
  int          quiet_cycles = 0;

  bit          trans_written [1024];
  bit          obs_written   [4096];
  bit          bel_written   [STATES];
  logic        cur_event = 1'b0;
  int          cur_count = STATES;

  initial forever #2 clk = ~clk;

  pomdp_belief_update_top u_dut (.*);

  pbu_belief_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .err_count, .pending
  );

  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0 && rx_idle >= 0) begin
      hold_cnt <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_cnt > 1) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      if (hold_cnt == 1) hold_cnt <= -1;
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [PROB_W-1:0] pick_prob();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 25) return ONE_Q16;
    if (r < 35) return PROB_W'($urandom_range(131071));
    return PROB_W'($urandom_range(65536));
  endfunction

  task automatic send_item(logic [2:0] f, logic [3:0] ps, logic [1:0] a, logic [3:0] ns,
                           logic [1:0] o, logic [PROB_W-1:0] p);
    bit ready;
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {3'b000, p, o, ns, a, ps};
    do begin
      @(negedge clk);
      ready = in_tready;
      @(posedge clk);
    end while (!ready);
    case (f)
      FUNC_LOAD_T: trans_written[{ps, a, ns}] = 1'b1;
      FUNC_LOAD_O: obs_written[{ps, a, ns, o}] = 1'b1;
      FUNC_LOAD_B: bel_written[ns] = 1'b1;
      default: ;
    endcase
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == REG_EVENT) cur_event = data[0];
    else begin
      cur_count = (data[4:0] == 0) ? 1 : (data[4:0] > STATES) ? STATES : int'(data[4:0]);
    end
  endtask

  // fill whatever entries the update will read, then issue it
  task automatic run_update(logic [1:0] a, logic [1:0] o);
    logic [3:0] ps;
    for (int n = 0; n < cur_count; n++) begin
      for (int s = 0; s < cur_count; s++) begin
        ps = cur_event ? 4'(s) : 4'd0;
        if (!trans_written[{4'(s), a, 4'(n)}])
          send_item(FUNC_LOAD_T, 4'(s), a, 4'(n), 2'($urandom), pick_prob());
        if (!obs_written[{ps, a, 4'(n), o}])
          send_item(FUNC_LOAD_O, ps, a, 4'(n), o, pick_prob());
      end
    end
    for (int s = 0; s < cur_count; s++)
      if (!bel_written[s]) send_item(FUNC_LOAD_B, 4'($urandom), 2'($urandom), 4'(s),
                                     2'($urandom), pick_prob());
    send_item(FUNC_UPDATE, 4'($urandom), a, 4'($urandom), o, PROB_W'($urandom));
  endtask

  task automatic random_items(int count);
    int         r;
    logic [3:0] idx;
    logic [1:0] a, o;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 25) begin
        a = 2'($urandom_range(1));
        o = 2'($urandom);
        if (cur_count > 8) begin
          a = 2'd1;
          o = 2'd2;
        end
        run_update(a, o);
      end else if (r < 45) begin
        send_item(FUNC_LOAD_T, 4'($urandom), 2'($urandom), 4'($urandom), 2'($urandom),
                  pick_prob());
      end else if (r < 60) begin
        send_item(FUNC_LOAD_O, 4'($urandom), 2'($urandom), 4'($urandom), 2'($urandom),
                  pick_prob());
      end else if (r < 70) begin
        send_item(FUNC_LOAD_B, 4'($urandom), 2'($urandom), 4'($urandom), 2'($urandom),
                  pick_prob());
      end else if (r < 90) begin
        idx = 4'($urandom);
        if (!bel_written[idx])
          send_item(FUNC_LOAD_B, 4'($urandom), 2'($urandom), idx, 2'($urandom), pick_prob());
        send_item(FUNC_READ_B, 4'($urandom), 2'($urandom), idx, 2'($urandom),
                  PROB_W'($urandom));
      end else begin
        send_item(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), 4'($urandom),
                  2'($urandom), 4'($urandom), 2'($urandom), PROB_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_EVENT, 32'd0);
    write_reg(REG_NSTATE, 32'd2);
    send_item(FUNC_LOAD_T, 4'd0, 2'd0, 4'd0, 2'd0, 17'h1FFFF);
    send_item(FUNC_LOAD_T, 4'd1, 2'd0, 4'd0, 2'd0, 17'd0);
    send_item(FUNC_LOAD_T, 4'd0, 2'd0, 4'd1, 2'd0, ONE_Q16);
    send_item(FUNC_LOAD_T, 4'd1, 2'd0, 4'd1, 2'd0, 17'd1);
    send_item(FUNC_LOAD_O, 4'd0, 2'd0, 4'd0, 2'd0, ONE_Q16);
    send_item(FUNC_LOAD_O, 4'd0, 2'd0, 4'd1, 2'd0, 17'h08000);
    send_item(FUNC_LOAD_B, 4'd0, 2'd0, 4'd0, 2'd0, ONE_Q16);
    send_item(FUNC_LOAD_B, 4'd0, 2'd0, 4'd1, 2'd0, 17'd0);
    send_item(FUNC_READ_B, 4'd0, 2'd0, 4'd0, 2'd0, 17'd0);
    run_update(2'd0, 2'd0);
    send_item(FUNC_READ_B, 4'd0, 2'd0, 4'd0, 2'd0, 17'd0);
    send_item(FUNC_READ_B, 4'd0, 2'd0, 4'd1, 2'd0, 17'd0);
    send_item(FUNC_LOAD_T, 4'd15, 2'd3, 4'd15, 2'd3, 17'h1FFFF);
    send_item(FUNC_LOAD_O, 4'd15, 2'd3, 4'd15, 2'd3, 17'h1FFFF);
    send_item(FUNC_LOAD_B, 4'd15, 2'd3, 4'd15, 2'd3, 17'h1FFFF);
    send_item(FUNC_READ_B, 4'd15, 2'd3, 4'd15, 2'd3, 17'h1FFFF);
    send_item(FUNC_SPARE_LO, 4'd15, 2'd3, 4'd15, 2'd3, 17'h1FFFF);
    send_item(3'd6, 4'd0, 2'd0, 4'd0, 2'd0, 17'd0);
    send_item(FUNC_SPARE_HI, 4'd5, 2'd1, 4'd10, 2'd2, 17'h0AAAA);
    // all-zero belief gives zero evidence and keeps the belief
    send_item(FUNC_LOAD_B, 4'd0, 2'd0, 4'd0, 2'd0, 17'd0);
    send_item(FUNC_LOAD_B, 4'd0, 2'd0, 4'd1, 2'd0, 17'd0);
    run_update(2'd0, 2'd0);
    send_item(FUNC_READ_B, 4'd0, 2'd0, 4'd0, 2'd0, 17'd0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0, 1: begin tx_idle = 26; rx_idle = 84; end
        2, 3: begin tx_idle = 84; rx_idle = 26; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      case (ph)
        0: begin write_reg(REG_EVENT, 32'd1); write_reg(REG_NSTATE, 32'd3); end
        1: begin write_reg(REG_EVENT, 32'd0); write_reg(REG_NSTATE, 32'd6); end
        2: begin write_reg(REG_EVENT, 32'd1); write_reg(REG_NSTATE, 32'd0); end
        3: begin write_reg(REG_EVENT, 32'd0); write_reg(REG_NSTATE, 32'd5); end
        4: begin write_reg(REG_EVENT, 32'd0); write_reg(REG_NSTATE, 32'd31); end
        default: begin write_reg(REG_EVENT, 32'd1); write_reg(REG_NSTATE, 32'd4); end
      endcase
      if (ph == 4) hold_req = 1'b1;
      random_items(30);
      hold_req = 1'b0;
    end

    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (50) @(posedge clk);
    if (err_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
